FILE: hdl/itrd_pkg.sv
// shared types, constants and symbol lookup for the radix digit converter
package itrd_pkg;

  localparam int VALUE_W     = 64;
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int SYM_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_DIGITS_DEF   = 64;
  localparam int SYMBOL_COUNT_DEF = 16;

  localparam logic [BASE_W-1:0]  MIN_BASE           = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_RESET         = 5'd10;
  localparam logic [VALUE_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [VALUE_W-1:0] SYMBOLS_HIGH_RESET = 64'h6665_6463_6261_3938;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_ERR
  } state_t;

  // control from the sequencer to the digit store and output stage
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load;
    logic err;
    logic last;
    logic neg;
  } emit_ctrl_t;

  function automatic logic [SYM_W-1:0] symbol_of(
    input logic [VALUE_W-1:0] sym_lo,
    input logic [VALUE_W-1:0] sym_hi,
    input logic [DIGIT_W-1:0] d
  );
    logic [VALUE_W-1:0] word;
    word = d[DIGIT_W-1] ? sym_hi : sym_lo;
    return word[d[DIGIT_W-2:0]*SYM_W +: SYM_W];
  endfunction

endpackage

FILE: hdl/itrd_div.sv
// bit-serial restoring divider: one quotient bit per cycle, small radix divisor
module itrd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [itrd_pkg::VALUE_W-1:0]      dividend,
  input  logic [itrd_pkg::BASE_W-1:0]       divisor,
  output logic                              done,
  output logic [itrd_pkg::VALUE_W-1:0]      quotient,
  output logic [itrd_pkg::DIGIT_W-1:0]      remainder,
  output logic                              quot_nz
);

  localparam int CW = $clog2(itrd_pkg::VALUE_W);

  logic [itrd_pkg::VALUE_W-1:0] q_r;
  logic [itrd_pkg::DIGIT_W-1:0] rem_r;
  logic [CW-1:0]                cnt_r;
  logic                         run_r;
  logic                         done_r;
  logic                         nz_r;

  logic [itrd_pkg::BASE_W-1:0]  trial;
  logic                         fits;
  logic [itrd_pkg::BASE_W-1:0]  diff;

  assign trial = {rem_r, q_r[itrd_pkg::VALUE_W-1]};
  assign fits  = trial >= divisor;
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      if (cnt_r == CW'(itrd_pkg::VALUE_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
      nz_r  <= 1'b0;
    end else if (run_r) begin
      q_r   <= {q_r[itrd_pkg::VALUE_W-2:0], fits};
      rem_r <= fits ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
      cnt_r <= cnt_r + 1'b1;
      nz_r  <= nz_r | fits;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
  assign quot_nz   = nz_r;

endmodule

FILE: hdl/itrd_emit.sv
// digit store, symbol lookup and output register
module itrd_emit #(
  parameter int DEPTH = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itrd_pkg::emit_ctrl_t              ctrl,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [itrd_pkg::DIGIT_W-1:0]      wr_digit,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  input  logic [itrd_pkg::VALUE_W-1:0]      symbols_low,
  input  logic [itrd_pkg::VALUE_W-1:0]      symbols_high,
  output logic                              slot_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [itrd_pkg::SYM_W-1:0]        out_symbol,
  output logic                              out_negative,
  output logic                              out_error,
  output logic                              out_last
);

  logic [itrd_pkg::DIGIT_W-1:0] store [DEPTH];
  logic [itrd_pkg::DIGIT_W-1:0] rd_data_r;

  logic                         valid_r;
  logic [itrd_pkg::SYM_W-1:0]   symbol_r;
  logic                         neg_r;
  logic                         err_r;
  logic                         last_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      store[wr_addr] <= wr_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      symbol_r <= ctrl.err ? '0
                           : itrd_pkg::symbol_of(symbols_low, symbols_high, rd_data_r);
      neg_r    <= ctrl.neg;
      err_r    <= ctrl.err;
      last_r   <= ctrl.last;
    end
  end

  assign out_valid    = valid_r;
  assign out_symbol   = symbol_r;
  assign out_negative = neg_r;
  assign out_error    = err_r;
  assign out_last     = last_r;

endmodule

FILE: hdl/integer_to_radix_digits_top.sv
// integer to radix digit symbols: sequencer, config registers, divider and output stage
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_kind, in_value
//  out_    | output    | out_valid/out_ready| out_symbol, out_negative, out_error, out_last
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// each digit comes from one run of the bit-serial divider (one quotient bit per cycle);
// once all digits are stored they are read back from the digit store, most significant
// first, one result per digit; a rejected base skips the divider and gives a single
// error result
// reset (rst_n low, synchronous) restores digit_base 10 and the "0123456789abcdef" table
// in_ready is high only while idle; a new transaction is taken while the last result waits
// a stalled out_ready holds the output register and pauses read-back
module integer_to_radix_digits_top #(
  parameter int MAX_DIGITS   = itrd_pkg::MAX_DIGITS_DEF,
  parameter int SYMBOL_COUNT = itrd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [itrd_pkg::VALUE_W-1:0]      in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [itrd_pkg::SYM_W-1:0]        out_symbol,
  output logic                              out_negative,
  output logic                              out_error,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::VALUE_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(MAX_DIGITS);

  logic [itrd_pkg::BASE_W-1:0]  digit_base_r;
  logic [itrd_pkg::VALUE_W-1:0] symbols_low_r;
  logic [itrd_pkg::VALUE_W-1:0] symbols_high_r;

  itrd_pkg::state_t             state_r, state_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;
  logic [AW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         neg_r, neg_nxt;

  logic                         base_bad;
  logic                         in_neg;
  logic [itrd_pkg::VALUE_W-1:0] magnitude;

  logic                         div_start;
  logic [itrd_pkg::VALUE_W-1:0] div_dividend;
  logic                         div_done;
  logic [itrd_pkg::VALUE_W-1:0] div_quot;
  logic [itrd_pkg::DIGIT_W-1:0] div_rem;
  logic                         div_nz;

  itrd_pkg::emit_ctrl_t         ectrl;
  logic                         slot_free;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_base_r   <= itrd_pkg::BASE_RESET;
      symbols_low_r  <= itrd_pkg::SYMBOLS_LOW_RESET;
      symbols_high_r <= itrd_pkg::SYMBOLS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itrd_pkg::CFG_DIGIT_BASE:   digit_base_r   <= cfg_wdata[itrd_pkg::BASE_W-1:0];
        itrd_pkg::CFG_SYMBOLS_LOW:  symbols_low_r  <= cfg_wdata;
        itrd_pkg::CFG_SYMBOLS_HIGH: symbols_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign base_bad  = (digit_base_r < itrd_pkg::MIN_BASE) ||
                     (digit_base_r > itrd_pkg::BASE_W'(SYMBOL_COUNT));
  assign in_neg    = in_kind && in_value[itrd_pkg::VALUE_W-1];
  assign magnitude = in_neg ? (itrd_pkg::VALUE_W'(0) - in_value) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    neg_r    <= neg_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    neg_nxt      = neg_r;
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    ectrl        = '0;
    unique case (state_r)
      itrd_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        div_dividend = magnitude;
        if (in_valid) begin
          neg_nxt = in_neg;
          cnt_nxt = '0;
          if (base_bad) begin
            state_nxt = itrd_pkg::ST_ERR;
          end else begin
            div_start = 1'b1;
            state_nxt = itrd_pkg::ST_DIV;
          end
        end
      end
      itrd_pkg::ST_DIV: begin
        ectrl.wr_en = div_done;
        if (div_done) begin
          // keep dividing while the quotient is nonzero and the store has room
          if (div_nz && (cnt_r != AW'(MAX_DIGITS - 1))) begin
            div_start = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            rd_idx_nxt = cnt_r;
            state_nxt  = itrd_pkg::ST_READ;
          end
        end
      end
      itrd_pkg::ST_READ: begin
        ectrl.rd_en = 1'b1;
        state_nxt   = itrd_pkg::ST_LOAD;
      end
      itrd_pkg::ST_LOAD: begin
        if (slot_free) begin
          ectrl.load = 1'b1;
          ectrl.neg  = neg_r;
          ectrl.last = (rd_idx_r == '0);
          if (rd_idx_r == '0) begin
            state_nxt = itrd_pkg::ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
            state_nxt  = itrd_pkg::ST_READ;
          end
        end
      end
      itrd_pkg::ST_ERR: begin
        if (slot_free) begin
          ectrl.load = 1'b1;
          ectrl.err  = 1'b1;
          ectrl.last = 1'b1;
          state_nxt  = itrd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itrd_pkg::ST_IDLE;
    endcase
  end

  itrd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (digit_base_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem),
    .quot_nz   (div_nz)
  );

  itrd_emit #(
    .DEPTH (MAX_DIGITS)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ectrl),
    .wr_addr      (cnt_r),
    .wr_digit     (div_rem),
    .rd_addr      (rd_idx_r),
    .symbols_low  (symbols_low_r),
    .symbols_high (symbols_high_r),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .out_negative (out_negative),
    .out_error    (out_error),
    .out_last     (out_last)
  );

  // divider finishes only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == itrd_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // a new result only appears after a load or error state
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      ($past(state_r) == itrd_pkg::ST_LOAD || $past(state_r) == itrd_pkg::ST_ERR))
    else $error("result appeared without a load");

  // an error result is a single zero symbol
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && out_symbol == '0 && !out_negative))
    else $error("malformed error result");

  // a bad base never starts the divider
  a_bad_base_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && base_bad) |=> (state_r == itrd_pkg::ST_ERR))
    else $error("rejected base did not go to error state");

endmodule
